FILE: hw/rtl/csvt_pkg.sv
package csvt_pkg;

  // Token kinds on the result channel
  localparam logic [1:0] KIND_CHAR       = 2'd0;
  localparam logic [1:0] KIND_FIELD_END  = 2'd1;
  localparam logic [1:0] KIND_RECORD_END = 2'd2;
  localparam logic [1:0] KIND_DISCARD    = 2'd3;

  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_QUOTE = 8'h22;

  localparam logic [7:0] SEP_RESET  = 8'h09;

  // Lead bytes dropped when skipping is enabled
  localparam logic [1:0] LEAD_BYTES = 2'd3;

  // Register map, word index taken from paddr[2]
  localparam logic REG_FIELD_SEPARATOR = 1'b0;
  localparam logic REG_SKIP_LEAD_BYTES = 1'b1;

  typedef struct packed {
    logic [7:0] field_separator;
    logic       skip_lead_bytes;
  } csvt_cfg_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [7:0] chr;
  } csvt_tok_t;

endpackage

FILE: hw/rtl/csv_field_tokenizer.sv
// CSV field tokenizer: one byte in, at most one token out.
// Output: a token is registered and appears on out_* in the cycle after its byte transfer.
// Throughput: one byte per cycle; the result register is reloaded in the
// same cycle it is drained, so only a stalled out_ready holds off input.
// Reset: synchronous, active low; clears parser state and the valid flag of
// the result register, field_separator returns to tab and skip_lead_bytes to 0.
module csv_field_tokenizer #(
  parameter int MAX_FIELD_CHARS = 511
) (
  input  logic        clk,
  input  logic        rst_n,
  // Byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_input,
  // Tokens
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_token_kind,
  output logic [7:0]  out_char_out,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  csvt_pkg::csvt_cfg_t cfg;
  csvt_pkg::csvt_tok_t tok;
  logic                stage_free;
  logic                in_acc;

  // A byte may transfer whenever the result register is empty or being
  // drained this cycle; bytes that make no token still pass straight on.
  assign in_ready = stage_free;
  assign in_acc   = in_valid && in_ready;

  // Separator and lead-byte skip; the user must write them only while the stream is idle, the block does not enforce it
  csvt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Quote, CR/LF and field-length tracking; the token is decided
  // combinationally from the incoming byte and the current flags.
  csvt_token_core #(
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .data_byte    (in_data_byte),
    .end_of_input (in_end_of_input),
    .cfg          (cfg),
    .tok          (tok)
  );

  // Single result register parting the two handshakes
  csvt_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (in_acc),
    .tok            (tok),
    .stage_free     (stage_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_kind (out_token_kind),
    .out_char_out   (out_char_out)
  );

endmodule

FILE: hw/rtl/csvt_cfg_regs.sv
module csvt_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output csvt_pkg::csvt_cfg_t cfg
);

  logic [7:0] sep_r;
  logic       skip_r;
  logic       wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r  <= csvt_pkg::SEP_RESET;
      skip_r <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2] == csvt_pkg::REG_FIELD_SEPARATOR) begin
        sep_r <= pwdata[7:0];
      end else begin
        skip_r <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == csvt_pkg::REG_SKIP_LEAD_BYTES) begin
      prdata = {31'd0, skip_r};
    end else begin
      prdata = {24'd0, sep_r};
    end
  end

  assign cfg.field_separator = sep_r;
  assign cfg.skip_lead_bytes = skip_r;

endmodule

FILE: hw/rtl/csvt_token_core.sv
module csvt_token_core #(
  parameter int MAX_FIELD_CHARS = 511
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          data_byte,
  input  logic                end_of_input,
  input  csvt_pkg::csvt_cfg_t cfg,
  output csvt_pkg::csvt_tok_t tok
);

  localparam int LW = $clog2(MAX_FIELD_CHARS + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_FIELD_CHARS);

  logic          in_quotes_r, in_quotes_nxt;
  logic          qpend_r, qpend_nxt;
  logic          after_cr_r, after_cr_nxt;
  logic [LW-1:0] flen_r, flen_nxt;
  logic [1:0]    lead_cnt_r, lead_cnt_nxt;
  logic          rec_open_r, rec_open_nxt;

  always_comb begin
    logic [7:0] b;
    logic       done;
    logic       put_chr;

    in_quotes_nxt = in_quotes_r;
    qpend_nxt     = qpend_r;
    after_cr_nxt  = after_cr_r;
    flen_nxt      = flen_r;
    lead_cnt_nxt  = lead_cnt_r;
    rec_open_nxt  = rec_open_r;
    tok           = '0;
    b             = data_byte;
    done          = 1'b0;
    put_chr       = 1'b0;

    if (end_of_input) begin
      tok.vld       = rec_open_r;
      tok.kind      = csvt_pkg::KIND_DISCARD;
      in_quotes_nxt = 1'b0;
      qpend_nxt     = 1'b0;
      after_cr_nxt  = 1'b0;
      flen_nxt      = '0;
      lead_cnt_nxt  = '0;
      rec_open_nxt  = 1'b0;
      done          = 1'b1;
    end

    if (!done && lead_cnt_r < csvt_pkg::LEAD_BYTES) begin
      lead_cnt_nxt = lead_cnt_r + 2'd1;
      done         = cfg.skip_lead_bytes;
    end

    // LF straight after CR is swallowed
    if (!done && after_cr_r) begin
      after_cr_nxt = 1'b0;
      done         = (b == csvt_pkg::BYTE_LF);
    end

    if (!done) begin
      if (b == csvt_pkg::BYTE_CR) begin
        b            = csvt_pkg::BYTE_LF;
        after_cr_nxt = 1'b1;
      end
      rec_open_nxt = 1'b1;

      if (qpend_r) begin
        qpend_nxt = 1'b0;
        if (b == csvt_pkg::BYTE_QUOTE) begin
          put_chr = 1'b1;
          done    = 1'b1;
        end else begin
          in_quotes_nxt = 1'b0;
        end
      end
    end

    if (!done) begin
      if (in_quotes_r && !qpend_r) begin
        if (b == csvt_pkg::BYTE_QUOTE) begin
          qpend_nxt = 1'b1;
        end else begin
          put_chr = 1'b1;
        end
      end else if (b == csvt_pkg::BYTE_QUOTE) begin
        in_quotes_nxt = 1'b1;
      end else if (b == csvt_pkg::BYTE_LF) begin
        flen_nxt     = '0;
        rec_open_nxt = 1'b0;
        tok.vld      = 1'b1;
        tok.kind     = csvt_pkg::KIND_RECORD_END;
      end else if (b == cfg.field_separator) begin
        flen_nxt = '0;
        tok.vld  = 1'b1;
        tok.kind = csvt_pkg::KIND_FIELD_END;
      end else begin
        put_chr = 1'b1;
      end
    end

    // Characters beyond the field limit are dropped
    if (put_chr && flen_r < LEN_MAX) begin
      flen_nxt = flen_r + LW'(1);
      tok.vld  = 1'b1;
      tok.kind = csvt_pkg::KIND_CHAR;
      tok.chr  = b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r <= 1'b0;
      qpend_r     <= 1'b0;
      after_cr_r  <= 1'b0;
      flen_r      <= '0;
      lead_cnt_r  <= '0;
      rec_open_r  <= 1'b0;
    end else if (acc) begin
      in_quotes_r <= in_quotes_nxt;
      qpend_r     <= qpend_nxt;
      after_cr_r  <= after_cr_nxt;
      flen_r      <= flen_nxt;
      lead_cnt_r  <= lead_cnt_nxt;
      rec_open_r  <= rec_open_nxt;
    end
  end

endmodule

FILE: hw/rtl/csvt_out_reg.sv
module csvt_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  csvt_pkg::csvt_tok_t tok,
  output logic                stage_free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_token_kind,
  output logic [7:0]          out_char_out
);

  logic       vld_r;
  logic [1:0] kind_r;
  logic [7:0] chr_r;

  assign stage_free = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (acc) begin
      vld_r <= tok.vld;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && tok.vld) begin
      kind_r <= tok.kind;
      chr_r  <= tok.chr;
    end
  end

  assign out_valid      = vld_r;
  assign out_token_kind = kind_r;
  assign out_char_out   = chr_r;

endmodule

FILE: hw/rtl/csvt_checker.sv
module csvt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_end_of_input,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_token_kind,
  input logic [7:0] out_char_out
);

  // A stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
    $stable(out_char_out))
    else $error("token changed while stalled");

  // Only data tokens carry a character
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != csvt_pkg::KIND_CHAR |-> out_char_out == 8'd0)
    else $error("non-data token with character");

  // End of input yields nothing or a discard
  a_eoi_discard: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_input |=>
    !out_valid || out_token_kind == csvt_pkg::KIND_DISCARD)
    else $error("end of input gave wrong token");

  // Input never held off while the result side can move
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free result stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("token valid after reset");

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_end_of_input (in_end_of_input),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_token_kind  (out_token_kind),
  .out_char_out    (out_char_out)
);
